[hw/rtl/sc1a_pkg.sv]
package sc1a_pkg;

	// scan code set 1 constants
	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam logic [6:0] KEY_CTRL    = 7'h1D;
	localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT  = 7'h36;
	localparam logic [6:0] KEY_ALT     = 7'h38;
	localparam logic [6:0] KEY_CAPS    = 7'h3A;
	localparam logic [7:0] KEY_LAST    = 8'h3A;

	// ascii codes touched by the ctrl rule
	localparam logic [6:0] CHAR_A = 7'h61;
	localparam logic [6:0] CHAR_L = 7'h6C;
	localparam logic [6:0] CHAR_U = 7'h75;

	// one decoded transaction headed for the result register
	typedef struct packed {
		logic       emit;
		logic [6:0] char_code;
		logic       unknown_key;
		logic       ctrl;
		logic       shift;
		logic       alt;
		logic       caps;
	} sc1a_result_t;

	// keys whose column follows shift alone
	function automatic logic is_symbol_key(input logic [7:0] code);
		return (code < 8'h0E) || (code == 8'h29) || (code == 8'h1A) || (code == 8'h1B) ||
			(code == 8'h34) || (code == 8'h2B) || (code == 8'h27) || (code == 8'h28) ||
			(code == 8'h33) || (code == 8'h35);
	endfunction

	// keymap rom: {unshifted, shifted}
	function automatic logic [13:0] keymap_row(input logic [5:0] idx);
		logic [13:0] row;
		unique case (idx)
			6'd1:  row = {7'h1B, 7'h1B};
			6'd2:  row = {7'h31, 7'h21};
			6'd3:  row = {7'h32, 7'h40};
			6'd4:  row = {7'h33, 7'h23};
			6'd5:  row = {7'h34, 7'h24};
			6'd6:  row = {7'h35, 7'h25};
			6'd7:  row = {7'h36, 7'h5E};
			6'd8:  row = {7'h37, 7'h26};
			6'd9:  row = {7'h38, 7'h2A};
			6'd10: row = {7'h39, 7'h28};
			6'd11: row = {7'h30, 7'h29};
			6'd12: row = {7'h2D, 7'h5F};
			6'd13: row = {7'h3D, 7'h2B};
			6'd14: row = {7'h08, 7'h08};
			6'd15: row = {7'h09, 7'h09};
			6'd16: row = {7'h71, 7'h51};
			6'd17: row = {7'h77, 7'h57};
			6'd18: row = {7'h65, 7'h45};
			6'd19: row = {7'h72, 7'h52};
			6'd20: row = {7'h74, 7'h54};
			6'd21: row = {7'h79, 7'h59};
			6'd22: row = {7'h75, 7'h55};
			6'd23: row = {7'h69, 7'h49};
			6'd24: row = {7'h6F, 7'h4F};
			6'd25: row = {7'h70, 7'h50};
			6'd26: row = {7'h5B, 7'h7B};
			6'd27: row = {7'h5D, 7'h7D};
			6'd28: row = {7'h0D, 7'h0D};
			6'd30: row = {7'h61, 7'h41};
			6'd31: row = {7'h73, 7'h53};
			6'd32: row = {7'h64, 7'h44};
			6'd33: row = {7'h66, 7'h46};
			6'd34: row = {7'h67, 7'h47};
			6'd35: row = {7'h68, 7'h48};
			6'd36: row = {7'h6A, 7'h4A};
			6'd37: row = {7'h6B, 7'h4B};
			6'd38: row = {7'h6C, 7'h4C};
			6'd39: row = {7'h3B, 7'h3A};
			6'd40: row = {7'h27, 7'h22};
			6'd41: row = {7'h60, 7'h7E};
			6'd43: row = {7'h5C, 7'h7C};
			6'd44: row = {7'h7A, 7'h5A};
			6'd45: row = {7'h78, 7'h58};
			6'd46: row = {7'h63, 7'h43};
			6'd47: row = {7'h76, 7'h56};
			6'd48: row = {7'h62, 7'h42};
			6'd49: row = {7'h6E, 7'h4E};
			6'd50: row = {7'h6D, 7'h4D};
			6'd51: row = {7'h2C, 7'h3C};
			6'd52: row = {7'h2E, 7'h3E};
			6'd53: row = {7'h2F, 7'h3F};
			6'd55: row = {7'h2A, 7'h2A};
			6'd57: row = {7'h20, 7'h20};
			default: row = 14'd0;
		endcase
		return row;
	endfunction

endpackage

[hw/rtl/sc1a_decode.sv]
module sc1a_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            scan_byte,
	input  logic                  step,
	output sc1a_pkg::sc1a_result_t result
);

	logic prefix_q, ctrl_q, shift_q, alt_q, caps_q;
	logic prefix_d, ctrl_d, shift_d, alt_d, caps_d;

	logic [6:0]  key7;
	logic        handled;
	logic        col;
	logic [13:0] row;
	logic [6:0]  ch;

	assign key7 = scan_byte[6:0];

	// lookup path for make codes
	always_comb begin
		if (sc1a_pkg::is_symbol_key(scan_byte)) begin
			col = shift_q;
		end else begin
			col = shift_q ^ caps_q;
		end
		row = sc1a_pkg::keymap_row(scan_byte[5:0]);
		ch  = col ? row[6:0] : row[13:7];
		if (ctrl_q && (ch == sc1a_pkg::CHAR_L || ch == sc1a_pkg::CHAR_U)) begin
			ch = ch - sc1a_pkg::CHAR_A;
		end
		if (prefix_q) begin
			handled = (key7 == sc1a_pkg::KEY_CTRL) || (key7 == sc1a_pkg::KEY_ALT);
		end else begin
			handled = (scan_byte != 8'd0) && (scan_byte <= sc1a_pkg::KEY_LAST);
		end
	end

	// next state and result for this transaction
	always_comb begin
		prefix_d = 1'b0;
		ctrl_d   = ctrl_q;
		shift_d  = shift_q;
		alt_d    = alt_q;
		caps_d   = caps_q;
		result.emit        = 1'b0;
		result.char_code   = 7'd0;
		result.unknown_key = 1'b0;
		if (scan_byte == sc1a_pkg::PREFIX_BYTE) begin
			prefix_d = 1'b1;
		end else if (scan_byte[7]) begin
			// break code releases a held modifier
			if (key7 == sc1a_pkg::KEY_CTRL) begin
				ctrl_d = 1'b0;
			end else if (!prefix_q &&
				(key7 == sc1a_pkg::KEY_LSHIFT || key7 == sc1a_pkg::KEY_RSHIFT)) begin
				shift_d = 1'b0;
			end else if (key7 == sc1a_pkg::KEY_ALT) begin
				alt_d = 1'b0;
			end
		end else if (handled) begin
			if (ch != 7'd0) begin
				result.emit      = 1'b1;
				result.char_code = ch;
			end else if (key7 == sc1a_pkg::KEY_CTRL) begin
				ctrl_d = 1'b1;
			end else if (!prefix_q &&
				(key7 == sc1a_pkg::KEY_LSHIFT || key7 == sc1a_pkg::KEY_RSHIFT)) begin
				shift_d = 1'b1;
			end else if (key7 == sc1a_pkg::KEY_ALT) begin
				alt_d = 1'b1;
			end else if (!prefix_q && key7 == sc1a_pkg::KEY_CAPS) begin
				caps_d = ~caps_q;
			end
		end else begin
			result.emit        = 1'b1;
			result.unknown_key = 1'b1;
		end
		// flags shown with a result are the ones after the step
		result.ctrl  = ctrl_d;
		result.shift = shift_d;
		result.alt   = alt_d;
		result.caps  = caps_d;
	end

	// modifier and prefix state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
			ctrl_q   <= 1'b0;
			shift_q  <= 1'b0;
			alt_q    <= 1'b0;
			caps_q   <= 1'b0;
		end else if (step) begin
			prefix_q <= prefix_d;
			ctrl_q   <= ctrl_d;
			shift_q  <= shift_d;
			alt_q    <= alt_d;
			caps_q   <= caps_d;
		end
	end

endmodule

[hw/rtl/scancode_set1_to_ascii.sv]
// scan code set 1 to ascii decoder
// a byte is held in the input register, decoded, and its result is then held in the result register
// throughput: one byte per cycle while the result register has room; the input register feeds the result register
// bytes that make no result (prefix, break, modifier make) leave the pipe without waiting for the result register
// reset: arst_n clears the prefix, ctrl, shift, alt and caps flags and both valid bits
module scancode_set1_to_ascii (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] char_code,
	output logic       unknown_key,
	output logic       ctrl_active,
	output logic       shift_active,
	output logic       alt_active,
	output logic       caps_active
);

	logic       valid_s1;
	logic [7:0] scan_byte_s1;
	logic       step;
	logic       out_free;
	sc1a_pkg::sc1a_result_t dec;

	logic       out_valid_q;
	logic [6:0] char_code_q;
	logic       unknown_key_q;
	logic       ctrl_q, shift_q, alt_q, caps_q;

	sc1a_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_byte (scan_byte_s1),
		.step      (step),
		.result    (dec)
	);

	// stage 1 advances when its result has room or it makes none
	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && (!dec.emit || out_free);
	assign in_ready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			scan_byte_s1 <= scan_byte;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && dec.emit;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (step && dec.emit) begin
			char_code_q   <= dec.char_code;
			unknown_key_q <= dec.unknown_key;
			ctrl_q        <= dec.ctrl;
			shift_q       <= dec.shift;
			alt_q         <= dec.alt;
			caps_q        <= dec.caps;
		end
	end

	assign out_valid    = out_valid_q;
	assign char_code    = char_code_q;
	assign unknown_key  = unknown_key_q;
	assign ctrl_active  = ctrl_q;
	assign shift_active = shift_q;
	assign alt_active   = alt_q;
	assign caps_active  = caps_q;

endmodule
